/* rtl/bwlp_pkg.sv */
// ----------------------------------------------------------------------------
// bwlp_pkg
// Shared types and constants for the fourth-order lowpass biquad cascade.
// ----------------------------------------------------------------------------
package bwlp_pkg;

    // Delay words and section outputs are 32-bit signed words with 8
    // fractional bits in sample units.
    localparam int STATE_W    = 32;
    localparam int STATE_FRAC = 8;
    // d + 2*w0 + w1 needs two guard bits over a delay word.
    localparam int SUM_W      = STATE_W + 2;

    localparam int CFG_ADDR_W = 3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN1 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FB11  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FB12  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FB21  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FB22  = 3'd4;

    // Reset values with 16 fractional bits.
    localparam int RST_FRAC  = 16;
    localparam int RST_GAIN1 = 1904;
    localparam int RST_FB11  = -33812;
    localparam int RST_FB12  = 6632;
    localparam int RST_FB21  = -45894;
    localparam int RST_FB22  = 32419;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S1_A1,
        ST_S1_A2,
        ST_S1_ACC,
        ST_S1_D,
        ST_S1_SUM,
        ST_S1_GAIN,
        ST_S1_Y,
        ST_S2_A1,
        ST_S2_A2,
        ST_S2_ACC,
        ST_S2_D,
        ST_S2_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_FB1,
        MUL_FB2,
        MUL_GAIN
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     idle;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     sec;
        logic     d_load;
        logic     sum_load;
        logic     y_load;
        logic     out_load;
    } ctrl_t;

endpackage

/* rtl/butterworth_lowpass_biquad_cascade.sv */
// ----------------------------------------------------------------------------
// butterworth_lowpass_biquad_cascade
// Fourth-order lowpass: two direct-form-II biquads on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream (s_tvalid, s_tready, s_tdata) takes one signed sample per
// item. The master stream (m_tvalid, m_tready, m_tdata, m_tuser) returns one
// item per sample: the input sample echoed, the filtered sample and a clip
// flag that is set when any delay word, section output or the final sample
// saturated.
// Each sample walks through a 13-step sequence around one multiplier and one
// accumulator: two feedback products per section and the first section's
// gain product, plus rounding, saturation and delay-line updates. The result
// enters the output register in the last step; from acceptance s_tready
// stays low until the sequence is back in idle, so no new sample is taken
// while one is in flight. The single multiplier sets the sequence length.
// The output register parts the two sides: a finished result may wait there
// while the next sample is being accepted and filtered. If the receiver
// keeps m_tready low, the sequence holds in its last step until the register
// frees, and then returns to idle.
// Reset clears all four delay words and loads the default coefficients. The
// configuration channel (cfg_valid, cfg_ready, cfg_addr, cfg_data) is always
// ready; writes to indexes beyond the five coefficients are dropped.
// ----------------------------------------------------------------------------
module butterworth_lowpass_biquad_cascade
    import bwlp_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Slave stream. s_tdata: sample_in.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // Master stream. m_tdata: raw_echo, filtered_out. m_tuser: clipped.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                  m_tuser,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  logic [COEF_FRAC_BITS+3:0]             cfg_data
);

    localparam int COEF_BITS   = COEF_FRAC_BITS + 4;
    localparam int PROD_W      = COEF_BITS + SUM_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int OUT_TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int COEF_UP     = (COEF_FRAC_BITS >= RST_FRAC) ? COEF_FRAC_BITS - RST_FRAC : 0;
    localparam int COEF_DN     = (COEF_FRAC_BITS < RST_FRAC) ? RST_FRAC - COEF_FRAC_BITS : 0;
    localparam int Y2R_W       = STATE_W + 1;

    localparam logic signed [COEF_BITS-1:0] GAIN1_RST = COEF_BITS'((RST_GAIN1 <<< COEF_UP) >>> COEF_DN);
    localparam logic signed [COEF_BITS-1:0] FB11_RST  = COEF_BITS'((RST_FB11 <<< COEF_UP) >>> COEF_DN);
    localparam logic signed [COEF_BITS-1:0] FB12_RST  = COEF_BITS'((RST_FB12 <<< COEF_UP) >>> COEF_DN);
    localparam logic signed [COEF_BITS-1:0] FB21_RST  = COEF_BITS'((RST_FB21 <<< COEF_UP) >>> COEF_DN);
    localparam logic signed [COEF_BITS-1:0] FB22_RST  = COEF_BITS'((RST_FB22 <<< COEF_UP) >>> COEF_DN);

    localparam logic signed [ACC_W-1:0]   RND_HALF  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [Y2R_W-1:0]   OUT_HALF  = Y2R_W'(1) <<< (STATE_FRAC - 1);
    localparam logic [STATE_W-1:0]        WORD_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic [STATE_W-1:0]        WORD_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0]    SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]    SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    ctrl_t ctrl;
    logic  take;
    logic  out_free;

    // Coefficient registers.
    logic signed [COEF_BITS-1:0] gain1_reg;
    logic signed [COEF_BITS-1:0] fb11_reg;
    logic signed [COEF_BITS-1:0] fb12_reg;
    logic signed [COEF_BITS-1:0] fb21_reg;
    logic signed [COEF_BITS-1:0] fb22_reg;

    // Delay lines of both sections.
    logic signed [STATE_W-1:0] w0_reg;
    logic signed [STATE_W-1:0] w1_reg;
    logic signed [STATE_W-1:0] v0_reg;
    logic signed [STATE_W-1:0] v1_reg;

    // Working registers.
    logic signed [STATE_W-1:0]     x_reg;
    logic signed [STATE_W-1:0]     d_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic        [SAMPLE_BITS-1:0] raw_reg;
    logic                          clip_reg;

    // Output register.
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] raw_out_reg;
    logic [SAMPLE_BITS-1:0] filt_out_reg;
    logic                   clip_out_reg;

    // Datapath signals.
    logic signed [STATE_W-1:0]   dl0;
    logic signed [STATE_W-1:0]   dl1;
    logic signed [COEF_BITS-1:0] op_a;
    logic signed [SUM_W-1:0]     op_b;
    logic signed [ACC_W-1:0]     load_val;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [ACC_W-1:0]     rnd_src;
    logic signed [ACC_W-1:0]     rnd;
    logic                        rnd_fits;
    logic signed [STATE_W-1:0]   rnd_sat;
    logic                        y2_fits;
    logic signed [STATE_W-1:0]   y2;
    logic signed [Y2R_W-1:0]     y2r;
    logic                        res_fits;
    logic [SAMPLE_BITS-1:0]      res;

    bwlp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (take),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    bwlp_mac #(
        .COEF_BITS (COEF_BITS),
        .OPB_W     (SUM_W),
        .ACC_W     (ACC_W)
    ) u_mac
    (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc_op   (ctrl.acc_op),
        .load_val (load_val),
        .prod     (prod),
        .acc      (acc)
    );

    assign s_tready  = ctrl.idle;
    assign take      = s_tvalid && ctrl.idle;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain1_reg <= GAIN1_RST;
            fb11_reg  <= FB11_RST;
            fb12_reg  <= FB12_RST;
            fb21_reg  <= FB21_RST;
            fb22_reg  <= FB22_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_GAIN1: gain1_reg <= cfg_data;
                REG_FB11:  fb11_reg  <= cfg_data;
                REG_FB12:  fb12_reg  <= cfg_data;
                REG_FB21:  fb21_reg  <= cfg_data;
                REG_FB22:  fb22_reg  <= cfg_data;
                default:   gain1_reg <= gain1_reg;
            endcase
        end
    end

    // The section bit picks which delay line feeds the multiplier and the sum.
    assign dl0 = ctrl.sec ? v0_reg : w0_reg;
    assign dl1 = ctrl.sec ? v1_reg : w1_reg;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_FB1:
            begin
                op_a = ctrl.sec ? fb21_reg : fb11_reg;
                op_b = SUM_W'(dl0);
            end
            MUL_FB2:
            begin
                op_a = ctrl.sec ? fb22_reg : fb12_reg;
                op_b = SUM_W'(dl1);
            end
            MUL_GAIN:
            begin
                op_a = gain1_reg;
                op_b = sum_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The section input is scaled up to the coefficient format before the
    // feedback products are taken off.
    assign load_val = ACC_W'(x_reg) <<< COEF_FRAC_BITS;

    assign sum_next = SUM_W'(d_reg) + (SUM_W'(dl0) <<< 1) + SUM_W'(dl1);

    // One round-half-up and 32-bit saturation path serves both the feedback
    // sum and the first section's gain product.
    assign rnd_src  = ctrl.y_load ? ACC_W'(prod) : acc;
    assign rnd      = (rnd_src + RND_HALF) >>> COEF_FRAC_BITS;
    assign rnd_fits = (&rnd[ACC_W-1:STATE_W-1]) || !(|rnd[ACC_W-1:STATE_W-1]);
    assign rnd_sat  = rnd_fits ? rnd[STATE_W-1:0] : (rnd[ACC_W-1] ? WORD_MIN : WORD_MAX);

    // Final stage: saturate the second section output, round to a sample.
    assign y2_fits  = (&sum_reg[SUM_W-1:STATE_W-1]) || !(|sum_reg[SUM_W-1:STATE_W-1]);
    assign y2       = y2_fits ? sum_reg[STATE_W-1:0] : (sum_reg[SUM_W-1] ? WORD_MIN : WORD_MAX);
    assign y2r      = (Y2R_W'(y2) + OUT_HALF) >>> STATE_FRAC;
    assign res_fits = (&y2r[Y2R_W-1:SAMPLE_BITS-1]) || !(|y2r[Y2R_W-1:SAMPLE_BITS-1]);
    assign res      = res_fits ? y2r[SAMPLE_BITS-1:0] : (y2r[Y2R_W-1] ? SMP_MIN : SMP_MAX);

    // Delay lines are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= '0;
            w1_reg <= '0;
            v0_reg <= '0;
            v1_reg <= '0;
        end
        else if (ctrl.sum_load)
        begin
            if (ctrl.sec)
            begin
                v1_reg <= v0_reg;
                v0_reg <= d_reg;
            end
            else
            begin
                w1_reg <= w0_reg;
                w0_reg <= d_reg;
            end
        end
    end

    // Working registers of the sequence.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg  <= s_tdata[SAMPLE_BITS-1:0];
            x_reg    <= STATE_W'($signed(s_tdata[SAMPLE_BITS-1:0])) <<< STATE_FRAC;
            clip_reg <= 1'b0;
        end
        else if (ctrl.y_load)
        begin
            x_reg    <= rnd_sat;
            clip_reg <= clip_reg || !rnd_fits;
        end
        else if (ctrl.d_load)
        begin
            clip_reg <= clip_reg || !rnd_fits;
        end
        if (ctrl.d_load)
        begin
            d_reg <= rnd_sat;
        end
        if (ctrl.sum_load)
        begin
            sum_reg <= sum_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            raw_out_reg  <= raw_reg;
            filt_out_reg <= res;
            clip_out_reg <= clip_reg || !y2_fits || !res_fits;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({filt_out_reg, raw_out_reg});
    assign m_tuser  = clip_out_reg;

endmodule

/* rtl/bwlp_mac.sv */
// ----------------------------------------------------------------------------
// bwlp_mac
// Shared multiplier with a registered product and a subtracting accumulator.
// ----------------------------------------------------------------------------
module bwlp_mac
    import bwlp_pkg::*;
#(
    parameter int COEF_BITS = 20,
    parameter int OPB_W     = 34,
    parameter int ACC_W     = 56
)
(
    input  logic                                clk,
    input  logic signed [COEF_BITS-1:0]         op_a,
    input  logic signed [OPB_W-1:0]             op_b,
    input  acc_op_t                             acc_op,
    input  logic signed [ACC_W-1:0]             load_val,
    output logic signed [COEF_BITS+OPB_W-1:0]   prod,
    output logic signed [ACC_W-1:0]             acc
);

    logic signed [COEF_BITS+OPB_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;

    always_comb
    begin
        case (acc_op)
            ACC_LOAD: acc_next = load_val;
            ACC_SUB:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

/* rtl/bwlp_ctrl.sv */
// ----------------------------------------------------------------------------
// bwlp_ctrl
// Sequencer that walks both biquad sections through the shared multiplier.
// ----------------------------------------------------------------------------
module bwlp_ctrl
    import bwlp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:    state_next = start ? ST_S1_A1 : ST_IDLE;
            ST_S1_A1:   state_next = ST_S1_A2;
            ST_S1_A2:   state_next = ST_S1_ACC;
            ST_S1_ACC:  state_next = ST_S1_D;
            ST_S1_D:    state_next = ST_S1_SUM;
            ST_S1_SUM:  state_next = ST_S1_GAIN;
            ST_S1_GAIN: state_next = ST_S1_Y;
            ST_S1_Y:    state_next = ST_S2_A1;
            ST_S2_A1:   state_next = ST_S2_A2;
            ST_S2_A2:   state_next = ST_S2_ACC;
            ST_S2_ACC:  state_next = ST_S2_D;
            ST_S2_D:    state_next = ST_S2_SUM;
            ST_S2_SUM:  state_next = ST_OUT;
            ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.mul_sel  = MUL_FB1;
        ctrl.acc_op   = ACC_HOLD;
        case (state_reg)
            ST_IDLE:    ctrl.idle = 1'b1;
            ST_S1_A1:   ctrl.acc_op = ACC_LOAD;
            ST_S1_A2:
            begin
                ctrl.mul_sel = MUL_FB2;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_S1_ACC:  ctrl.acc_op = ACC_SUB;
            ST_S1_D:    ctrl.d_load = 1'b1;
            ST_S1_SUM:  ctrl.sum_load = 1'b1;
            ST_S1_GAIN: ctrl.mul_sel = MUL_GAIN;
            ST_S1_Y:    ctrl.y_load = 1'b1;
            ST_S2_A1:
            begin
                ctrl.sec    = 1'b1;
                ctrl.acc_op = ACC_LOAD;
            end
            ST_S2_A2:
            begin
                ctrl.sec     = 1'b1;
                ctrl.mul_sel = MUL_FB2;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_S2_ACC:
            begin
                ctrl.sec    = 1'b1;
                ctrl.acc_op = ACC_SUB;
            end
            ST_S2_D:
            begin
                ctrl.sec    = 1'b1;
                ctrl.d_load = 1'b1;
            end
            ST_S2_SUM:
            begin
                ctrl.sec      = 1'b1;
                ctrl.sum_load = 1'b1;
            end
            ST_OUT:     ctrl.out_load = out_free;
            default:    ctrl.idle = 1'b0;
        endcase
    end

endmodule

/* rtl/bwlp_checker.sv */
// ----------------------------------------------------------------------------
// bwlp_checker
// Port-level checks of the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module bwlp_checker
    import bwlp_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    input logic                                  m_tuser,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input logic [COEF_FRAC_BITS+3:0]             cfg_data
);

    // The filter stays busy after it takes a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input taken again too soon after a sample");

    // No result can appear the cycle right after a sample is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared without filter latency");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Configuration is always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind butterworth_lowpass_biquad_cascade bwlp_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
) u_bwlp_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-section fixed-point lowpass cascade.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream and filtered items come back on the
// master stream. Both sides pause at random. A scoreboard runs its own
// bit-exact fixed-point filter on every accepted sample and compares each
// returned item field by field. The coefficients are reloaded between
// phases, only while the block is idle: the reset values, random stable
// sets, random sets that blow up, and the register extremes.
// ----------------------------------------------------------------------------
module testbench;
    import bwlp_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_FRAC      = 16;
    localparam int COEF_W         = COEF_FRAC + 4;
    localparam int PHASE_ITEMS    = 120;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // Coefficient sets used by the random phases.
    typedef enum int {
        COEF_DEFAULT,
        COEF_STABLE,
        COEF_WILD
    } coef_mode_t;

    // One returned item as the block should produce it.
    typedef struct {
        logic signed [SAMPLE_W-1:0] echo;
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       clipped;
    } filter_result_t;

    // Tracks coefficients and delay words, predicts the filter output for
    // every accepted sample and checks the returned items in order.
    class biquad_scoreboard;
        longint         coef[5];
        longint         s1_w[2];
        longint         s2_w[2];
        filter_result_t pending_outputs[$];
        int             errors = 0;

        function void power_on();
            coef[REG_GAIN1] = RST_GAIN1;
            coef[REG_FB11]  = RST_FB11;
            coef[REG_FB12]  = RST_FB12;
            coef[REG_FB21]  = RST_FB21;
            coef[REG_FB22]  = RST_FB22;
            s1_w[0] = 0;
            s1_w[1] = 0;
            s2_w[0] = 0;
            s2_w[1] = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COEF_W-1:0] data);
            longint value;
            value = $signed(data);
            // Indexes past the last coefficient are dropped by the block.
            if (idx <= REG_FB22)
                coef[idx] = value;
        endfunction

        // Floor of (v + half) / 2^sh; the signed shift already floors.
        function longint round_off(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function longint clamp(longint v, int bits, inout bit hit);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // New delay word of one section: x - a1*w0 - a2*w1, exact then rounded.
        function longint next_delay(longint x, longint w0, longint w1,
                                    longint a1, longint a2, inout bit hit);
            longint acc;
            acc = (x <<< COEF_FRAC) - a1 * w0 - a2 * w1;
            return clamp(round_off(acc, COEF_FRAC), STATE_W, hit);
        endfunction

        function filter_result_t filter_sample(logic signed [SAMPLE_W-1:0] smp);
            filter_result_t r;
            bit             hit;
            longint         x;
            longint         d;
            longint         y1;
            longint         y2;
            longint         y1_sum;
            hit = 1'b0;
            x = smp;
            x = x <<< STATE_FRAC;

            d = next_delay(x, s1_w[0], s1_w[1], coef[REG_FB11], coef[REG_FB12], hit);
            y1_sum = d + 2 * s1_w[0] + s1_w[1];
            y1 = clamp(round_off(coef[REG_GAIN1] * y1_sum, COEF_FRAC), STATE_W, hit);
            s1_w[1] = s1_w[0];
            s1_w[0] = d;

            d = next_delay(y1, s2_w[0], s2_w[1], coef[REG_FB21], coef[REG_FB22], hit);
            y2 = clamp(d + 2 * s2_w[0] + s2_w[1], STATE_W, hit);
            s2_w[1] = s2_w[0];
            s2_w[0] = d;

            r.echo     = smp;
            r.filtered = SAMPLE_W'(clamp(round_off(y2, STATE_FRAC), SAMPLE_W, hit));
            r.clipped  = hit;
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp);
            pending_outputs.push_back(filter_sample(smp));
        endfunction

        function void flag(string what, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        endfunction

        function void check_result(logic [2*SAMPLE_W-1:0] tdata, logic tuser);
            filter_result_t want;
            if (pending_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: item with no sample waiting, expected none, actual %0d",
                         $time, $signed(tdata[2*SAMPLE_W-1:SAMPLE_W]));
                return;
            end
            want = pending_outputs.pop_front();
            if (tdata[SAMPLE_W-1:0] !== want.echo)
                flag("raw_echo", want.echo, $signed(tdata[SAMPLE_W-1:0]));
            if (tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.filtered)
                flag("filtered_out", want.filtered, $signed(tdata[2*SAMPLE_W-1:SAMPLE_W]));
            if (tuser !== want.clipped)
                flag("clipped", want.clipped, tuser);
        endfunction
    endclass

    // Block ports. Every input holds a known value from time zero.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [SAMPLE_W-1:0]       s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0]     m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_ADDR_W-1:0]     cfg_addr  = '0;
    logic [COEF_W-1:0]         cfg_data  = '0;

    biquad_scoreboard sb = new;

    // When set, the sample source offers items back to back.
    bit tx_no_gaps = 1'b0;

    butterworth_lowpass_biquad_cascade dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offers one sample after a random gap and holds it until accepted.
    // All port values are read just after the edge, so they are the values
    // the block saw at that edge. tvalid stays high when the next sample
    // follows without a gap.
    task automatic send_sample(logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(smp);
    endtask

    // Stops offering samples and waits until every predicted item is back.
    // The loop waits on an edge before its check, so a following tvalid rise
    // never shares a time step with this fall.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_outputs.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Loads all five coefficients, then throws in one write to an unused
    // index, which the block must ignore. Call only while the block is idle.
    task automatic load_coefs(int gain, int a11, int a12, int a21, int a22);
        cfg_write(REG_GAIN1, gain[COEF_W-1:0]);
        cfg_write(REG_FB11,  a11[COEF_W-1:0]);
        cfg_write(REG_FB12,  a12[COEF_W-1:0]);
        cfg_write(REG_FB21,  a21[COEF_W-1:0]);
        cfg_write(REG_FB22,  a22[COEF_W-1:0]);
        cfg_write(CFG_ADDR_W'($urandom_range(REG_FB22 + 1, 7)), COEF_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // A random section pair inside the stability triangle, |a2| < 0.9 and
    // |a1| < 0.95 * (1 + a2), with a gain up to two.
    task automatic load_stable_coefs();
        int a1[2];
        int a2[2];
        int lim;
        int gain;
        for (int k = 0; k < 2; k++)
        begin
            a2[k] = int'($urandom_range(0, 117964)) - 58982;
            lim   = ((65536 + a2[k]) * 95) / 100;
            a1[k] = int'($urandom_range(0, 2 * lim)) - lim;
        end
        gain = int'($urandom_range(0, 262144)) - 131072;
        load_coefs(gain, a1[0], a2[0], a1[1], a2[1]);
    endtask

    // Mostly full-range noise, with small values and values at the rails.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_W'($urandom_range(0, 1) ? 16'h7FFF - $urandom_range(0, 3)
                                                           : 16'h8000 + $urandom_range(0, 3));
            1, 2:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result sink: random stalls per item, bursts with no stalls, and two
    // long hold-offs that let the block back up into its input side.
    initial
    begin : result_sink
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (taken == 150 || taken == 600)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata, m_tuser);
            taken++;
        end
    end

    // Ends the run when no channel has moved an item for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        coef_mode_t plan[8];
        int         pause_at;
        plan = '{COEF_DEFAULT, COEF_STABLE, COEF_WILD, COEF_STABLE,
                 COEF_STABLE, COEF_WILD, COEF_STABLE, COEF_DEFAULT};
        sb.power_on();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: zero, steps to both rails, alternating bit
        // patterns and the smallest nonzero values.
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // Largest gain with no feedback: the final sample runs into its limit.
        wait_drained();
        load_coefs(524287, 0, 0, 0, 0);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);

        // Every register at its most negative value: the feedback grows
        // without bound and the delay words saturate.
        wait_drained();
        load_coefs(-524288, -524288, -524288, -524288, -524288);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);

        // Every register at its most positive value.
        wait_drained();
        load_coefs(524287, 524287, 524287, 524287, 524287);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);

        // Random phases. Each reloads the coefficients on an idle block and
        // pauses once in the middle until every item has come back. A stable
        // set after a wild one lets the saturated delay words decay again.
        foreach (plan[p])
        begin
            wait_drained();
            case (plan[p])
                COEF_DEFAULT: load_coefs(RST_GAIN1, RST_FB11, RST_FB12, RST_FB21, RST_FB22);
                COEF_STABLE:  load_stable_coefs();
                COEF_WILD:    load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
                default:      load_stable_coefs();
            endcase
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            pause_at   = $urandom_range(10, PHASE_ITEMS - 10);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                send_sample(random_sample());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
